// ----- sv/lobu_pkg.sv -----
`timescale 1ns / 1ps
package lobu_pkg;

  // event codes carried in the input tuser
  localparam logic [2:0] CMD_BAD    = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_PCAN   = 3'd2;
  localparam logic [2:0] CMD_DEL    = 3'd3;
  localparam logic [2:0] CMD_EXEC   = 3'd4;
  localparam logic [2:0] CMD_HIDDEN = 3'd5;
  localparam logic [2:0] CMD_CROSS  = 3'd6;
  localparam logic [2:0] CMD_HALT   = 3'd7;

  // result status codes
  localparam logic [3:0] STS_APPLIED    = 4'd0;
  localparam logic [3:0] STS_NONPOS     = 4'd1;
  localparam logic [3:0] STS_BAD_SIDE   = 4'd2;
  localparam logic [3:0] STS_UNKNOWN    = 4'd3;
  localparam logic [3:0] STS_REPLACED   = 4'd4;
  localparam logic [3:0] STS_NO_LEVEL   = 4'd5;
  localparam logic [3:0] STS_BAD_EVENT  = 4'd6;
  localparam logic [3:0] STS_ORD_FULL   = 4'd7;
  localparam logic [3:0] STS_LVL_FULL   = 4'd8;

  localparam logic [1:0] SIDE_BID = 2'b01;
  localparam logic [1:0] SIDE_ASK = 2'b11;

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 184;

  // result field offsets inside the output tdata
  localparam int OFS_BB      = 4;
  localparam int OFS_BBV     = 36;
  localparam int OFS_BA      = 37;
  localparam int OFS_BAV     = 69;
  localparam int OFS_HALT    = 70;
  localparam int OFS_LIVE    = 71;
  localparam int OFS_HIDDEN  = 82;
  localparam int OFS_CROSS   = 114;
  localparam int OFS_UNKNOWN = 146;
  localparam int OUT_USED_W  = 178;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ORD_RD,
    ST_ORD_CHK,
    ST_ORD_DONE,
    ST_LVL_RD,
    ST_LVL_CHK,
    ST_LVL_DONE,
    ST_ADD_PREP,
    ST_BEST_RD,
    ST_BEST_CHK,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CTX_REDUCE,
    CTX_REPLACE,
    CTX_ADD
  } ctx_e;

endpackage

// ----- sv/limit_order_book_update_core.sv -----
`timescale 1ns / 1ps
// Limit order book update core. One market event enters per request on the slave
// stream (event code in tuser, id, side, price and size in tdata) and exactly one
// result leaves on the master stream: status, best bid and ask with valid flags,
// halt flag, live order count and the saturating hidden, cross and unknown-id
// counters. The order table and the bid/ask level tables sit in memories with one
// write port and one registered read port, which one small sequencer walks entry
// by entry (address, then registered read and compare). An event runs an id
// search over every order slot (skipped by hidden, cross, halt and rejected
// events), level searches over one side (one for a reduce or a plain add, two for
// an add that replaces an order) and a sweep over every level of both sides for
// the best prices, besides decode and hand-off. tready is high only between events. A
// finished result waits in the output register, so the next request can be taken
// while it is still pending. After reset a clearing pass over every order and
// level slot empties the tables before the first request is accepted.
module limit_order_book_update_core #(
  parameter int ORDER_SLOTS     = 1024,
  parameter int LEVELS_PER_SIDE = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // id[31:0], side[33:32], price[65:34], size[97:66]
  input  logic [lobu_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // command[2:0]
  input  logic [lobu_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status[3:0], best_bid[35:4], best_bid_valid[36], best_ask[68:37],
  // best_ask_valid[69], halt_flag[70], live_orders[81:71], hidden_count[113:82],
  // cross_count[145:114], unknown_count[177:146]
  output logic [lobu_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import lobu_pkg::*;

  localparam int LEVEL_SLOTS = 2 * LEVELS_PER_SIDE;
  localparam int OAW  = $clog2(ORDER_SLOTS);
  localparam int LAW  = $clog2(LEVEL_SLOTS);
  localparam int LSW  = $clog2(LEVELS_PER_SIDE);
  localparam int LCW  = $clog2(ORDER_SLOTS + 1);
  localparam int LTW  = 32 + $clog2(ORDER_SLOTS);
  localparam int LCNT = (LCW > 11) ? LCW : 11;
  localparam int CLR_N = (ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS;
  localparam int CW   = $clog2(CLR_N + 1);
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // order table memory
  logic               ord_used_m  [ORDER_SLOTS];
  logic [31:0]        ord_key_m   [ORDER_SLOTS];
  logic signed [31:0] ord_price_m [ORDER_SLOTS];
  logic signed [31:0] ord_rem_m   [ORDER_SLOTS];
  logic               ord_bid_m   [ORDER_SLOTS];

  // level table memory, bid levels first then ask levels
  logic                 lvl_used_m  [LEVEL_SLOTS];
  logic signed [31:0]   lvl_price_m [LEVEL_SLOTS];
  logic signed [LTW-1:0] lvl_total_m [LEVEL_SLOTS];
  logic [LCW-1:0]       lvl_cnt_m   [LEVEL_SLOTS];

  // registered read data
  logic               or_used_q, or_bid_q;
  logic [31:0]        or_key_q;
  logic signed [31:0] or_price_q, or_rem_q;
  logic                  lr_used_q;
  logic signed [31:0]    lr_price_q;
  logic signed [LTW-1:0] lr_total_q;
  logic [LCW-1:0]        lr_cnt_q;

  // write ports
  logic               o_we;
  logic [OAW-1:0]     o_waddr;
  logic               o_wused, o_wbid;
  logic [31:0]        o_wkey;
  logic signed [31:0] o_wprice, o_wrem;
  logic                  l_we;
  logic [LAW-1:0]        l_waddr;
  logic                  l_wused;
  logic signed [31:0]    l_wprice;
  logic signed [LTW-1:0] l_wtotal;
  logic [LCW-1:0]        l_wcnt;
  logic [LAW-1:0]        lvl_raddr;
  logic [LAW-1:0]        lvl_saddr;

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;
  logic [CW-1:0]   cc_q, cc_d;

  // latched request
  logic [2:0]         cmd_q, cmd_d;
  logic [31:0]        id_q, id_d;
  logic [1:0]         side_q, side_d;
  logic signed [31:0] price_q, price_d;
  logic signed [31:0] size_q, size_d;

  // book state
  logic            halt_q, halt_d;
  logic [31:0]     hid_q, hid_d, crs_q, crs_d, unk_q, unk_d;
  logic [LCNT-1:0] live_q, live_d;

  logic [3:0] status_q, status_d;
  logic       replaced_q, replaced_d;

  // id search
  logic [OAW-1:0]     oc_q, oc_d, fidx_q, fidx_d, ofree_q, ofree_d;
  logic               ofound_q, ofound_d, ofree_v_q, ofree_v_d;
  logic signed [31:0] o_price_q, o_price_d, o_rem_q, o_rem_d;
  logic               o_bid_q, o_bid_d;
  logic signed [31:0] delta_q, delta_d;

  // level search
  logic [LSW-1:0]        lc_q, lc_d;
  logic [LAW-1:0]        lidx_q, lidx_d, lfree_q, lfree_d;
  logic                  lfound_q, lfound_d, lfree_v_q, lfree_v_d;
  logic signed [LTW-1:0] l_total_q, l_total_d;
  logic [LCW-1:0]        l_cnt_q, l_cnt_d;
  logic                  tgt_bid_q, tgt_bid_d;
  logic signed [31:0]    tgt_price_q, tgt_price_d;

  // best price sweep
  logic [LAW-1:0]     bc_q, bc_d;
  logic signed [31:0] bb_q, bb_d, ba_q, ba_d;
  logic               bbv_q, bbv_d, bav_q, bav_d;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // shared decision terms
  logic               s_accept, size_bad, side_ok, oc_last, lc_last, bc_last, emit_go;
  logic signed [31:0] amount, delta, new_rem;
  logic               slot_v;
  logic [OAW-1:0]     slot;
  logic [LCW-1:0]     cnt_after;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign size_bad = size_q <= 32'sd0;
  assign side_ok  = (side_q == SIDE_BID) || (side_q == SIDE_ASK);
  assign oc_last  = oc_q == OAW'(ORDER_SLOTS - 1);
  assign lc_last  = lc_q == LSW'(LEVELS_PER_SIDE - 1);
  assign bc_last  = bc_q == LAW'(LEVEL_SLOTS - 1);
  assign emit_go  = !m_valid_q || m_axis_tready_i;

  // a delete or a replacement takes the whole remainder
  assign amount = (((cmd_q == CMD_ADD) || (cmd_q == CMD_DEL)) && ofound_q) ? o_rem_q : size_q;
  assign delta  = (amount < o_rem_q) ? amount : o_rem_q;
  assign new_rem = o_rem_q - delta_q;
  assign cnt_after = ((new_rem == 32'sd0) && (l_cnt_q != '0)) ? l_cnt_q - LCW'(1) : l_cnt_q;

  // slot freed by a replacement counts as free
  assign slot_v = ofree_v_q || ofound_q;
  always_comb begin
    if (ofound_q && !(ofree_v_q && (ofree_q < fidx_q))) begin
      slot = fidx_q;
    end else begin
      slot = ofree_q;
    end
  end

  assign lvl_saddr = (tgt_bid_q ? LAW'(0) : LAW'(LEVELS_PER_SIDE)) + LAW'(lc_q);
  assign lvl_raddr = (state_q == ST_BEST_RD) ? bc_q : lvl_saddr;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (cc_q == CW'(CLR_N - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (cmd_q)
          CMD_ADD:            state_d = (size_bad || !side_ok) ? ST_BEST_RD : ST_ORD_RD;
          CMD_PCAN, CMD_EXEC: state_d = size_bad ? ST_BEST_RD : ST_ORD_RD;
          CMD_DEL:            state_d = ST_ORD_RD;
          default:            state_d = ST_BEST_RD;
        endcase
      end
      ST_ORD_RD:  state_d = ST_ORD_CHK;
      ST_ORD_CHK: state_d = oc_last ? ST_ORD_DONE : ST_ORD_RD;
      ST_ORD_DONE: begin
        if (cmd_q == CMD_ADD) begin
          state_d = (ofound_q && (delta > 32'sd0)) ? ST_LVL_RD : ST_ADD_PREP;
        end else begin
          state_d = (ofound_q && (amount > 32'sd0) && (delta > 32'sd0)) ? ST_LVL_RD
                                                                         : ST_BEST_RD;
        end
      end
      ST_LVL_RD:   state_d = ST_LVL_CHK;
      ST_LVL_CHK:  state_d = lc_last ? ST_LVL_DONE : ST_LVL_RD;
      ST_LVL_DONE: state_d = (ctx_q == CTX_REPLACE) ? ST_ADD_PREP : ST_BEST_RD;
      ST_ADD_PREP: state_d = slot_v ? ST_LVL_RD : ST_BEST_RD;
      ST_BEST_RD:  state_d = ST_BEST_CHK;
      ST_BEST_CHK: state_d = bc_last ? ST_EMIT : ST_BEST_RD;
      ST_EMIT:     state_d = emit_go ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    s_axis_tready_o = state_q == ST_IDLE;
    cc_d = cc_q;  ctx_d = ctx_q;
    cmd_d = cmd_q;  id_d = id_q;  side_d = side_q;  price_d = price_q;  size_d = size_q;
    halt_d = halt_q;  hid_d = hid_q;  crs_d = crs_q;  unk_d = unk_q;  live_d = live_q;
    status_d = status_q;  replaced_d = replaced_q;
    oc_d = oc_q;  fidx_d = fidx_q;  ofree_d = ofree_q;  ofound_d = ofound_q;
    ofree_v_d = ofree_v_q;  o_price_d = o_price_q;  o_rem_d = o_rem_q;  o_bid_d = o_bid_q;
    delta_d = delta_q;
    lc_d = lc_q;  lidx_d = lidx_q;  lfree_d = lfree_q;  lfound_d = lfound_q;
    lfree_v_d = lfree_v_q;  l_total_d = l_total_q;  l_cnt_d = l_cnt_q;
    tgt_bid_d = tgt_bid_q;  tgt_price_d = tgt_price_q;
    bc_d = bc_q;  bb_d = bb_q;  ba_d = ba_q;  bbv_d = bbv_q;  bav_d = bav_q;
    m_valid_d = (m_valid_q && !m_axis_tready_i);
    m_data_d = m_data_q;
    o_we = 1'b0;  o_waddr = fidx_q;  o_wused = 1'b0;  o_wkey = id_q;
    o_wprice = o_price_q;  o_wrem = o_rem_q;  o_wbid = o_bid_q;
    l_we = 1'b0;  l_waddr = lidx_q;  l_wused = 1'b0;  l_wprice = tgt_price_q;
    l_wtotal = l_total_q;  l_wcnt = l_cnt_q;

    case (state_q)
      ST_CLEAR: begin
        o_we    = cc_q < CW'(ORDER_SLOTS);
        o_waddr = cc_q[OAW-1:0];
        l_we    = cc_q < CW'(LEVEL_SLOTS);
        l_waddr = cc_q[LAW-1:0];
        cc_d    = cc_q + CW'(1);
      end
      ST_IDLE: begin
        if (s_accept) begin
          cmd_d   = s_axis_tuser_i;
          id_d    = s_axis_tdata_i[31:0];
          side_d  = s_axis_tdata_i[33:32];
          price_d = s_axis_tdata_i[65:34];
          size_d  = s_axis_tdata_i[97:66];
          // an add resumes trading before it is applied
          if (halt_q && (s_axis_tuser_i == CMD_ADD)) halt_d = 1'b0;
          status_d = STS_APPLIED;  replaced_d = 1'b0;
          oc_d = '0;  ofound_d = 1'b0;  ofree_v_d = 1'b0;
          bc_d = '0;  bbv_d = 1'b0;  bav_d = 1'b0;  bb_d = '0;  ba_d = '0;
        end
      end
      ST_DECODE: begin
        case (cmd_q)
          CMD_ADD: begin
            if (size_bad) status_d = STS_NONPOS;
            else if (!side_ok) status_d = STS_BAD_SIDE;
          end
          CMD_PCAN, CMD_EXEC: begin
            if (size_bad) status_d = STS_NONPOS;
          end
          CMD_DEL: ;
          CMD_HIDDEN: hid_d = (hid_q == CNT_MAX) ? hid_q : hid_q + 32'd1;
          CMD_CROSS:  crs_d = (crs_q == CNT_MAX) ? crs_q : crs_q + 32'd1;
          CMD_HALT:   halt_d = price_q != 32'sd1;
          default:    status_d = STS_BAD_EVENT;
        endcase
      end
      ST_ORD_CHK: begin
        if (or_used_q && (or_key_q == id_q) && !ofound_q) begin
          ofound_d = 1'b1;  fidx_d = oc_q;
          o_price_d = or_price_q;  o_rem_d = or_rem_q;  o_bid_d = or_bid_q;
        end
        if (!or_used_q && !ofree_v_q) begin
          ofree_v_d = 1'b1;  ofree_d = oc_q;
        end
        oc_d = oc_q + OAW'(1);
      end
      ST_ORD_DONE: begin
        lc_d = '0;  lfound_d = 1'b0;  lfree_v_d = 1'b0;
        tgt_bid_d = o_bid_q;  tgt_price_d = o_price_q;  delta_d = delta;
        if (cmd_q == CMD_ADD) begin
          replaced_d = ofound_q;
          ctx_d = CTX_REPLACE;
        end else begin
          ctx_d = CTX_REDUCE;
          if (!ofound_q) begin
            if (amount <= 32'sd0) begin
              status_d = STS_NONPOS;
            end else begin
              unk_d = (unk_q == CNT_MAX) ? unk_q : unk_q + 32'd1;
              status_d = STS_UNKNOWN;
            end
          end else if (amount <= 32'sd0) begin
            status_d = STS_NONPOS;
          end
        end
      end
      ST_LVL_CHK: begin
        if (lr_used_q && (lr_price_q == tgt_price_q) && !lfound_q) begin
          lfound_d = 1'b1;  lidx_d = lvl_saddr;
          l_total_d = lr_total_q;  l_cnt_d = lr_cnt_q;
        end
        if (!lr_used_q && !lfree_v_q) begin
          lfree_v_d = 1'b1;  lfree_d = lvl_saddr;
        end
        lc_d = lc_q + LSW'(1);
      end
      ST_LVL_DONE: begin
        if (ctx_q == CTX_ADD) begin
          if (!lfound_q && !lfree_v_q) begin
            status_d = STS_LVL_FULL;
          end else begin
            l_we     = 1'b1;
            l_waddr  = lfound_q ? lidx_q : lfree_q;
            l_wused  = 1'b1;
            l_wprice = price_q;
            l_wtotal = (lfound_q ? l_total_q : '0) + {{(LTW-32){size_q[31]}}, size_q};
            l_wcnt   = (lfound_q ? l_cnt_q : '0) + LCW'(1);
            o_we     = 1'b1;
            o_waddr  = slot;
            o_wused  = 1'b1;
            o_wkey   = id_q;
            o_wprice = price_q;
            o_wrem   = size_q;
            o_wbid   = side_q == SIDE_BID;
            live_d   = live_q + LCNT'(1);
            status_d = replaced_q ? STS_REPLACED : STS_APPLIED;
          end
        end else if (!lfound_q) begin
          // order without its level is dropped
          o_we = 1'b1;
          if (live_q != '0) live_d = live_q - LCNT'(1);
          if (ctx_q == CTX_REDUCE) status_d = STS_NO_LEVEL;
        end else begin
          o_we    = 1'b1;
          o_wused = new_rem != 32'sd0;
          o_wrem  = new_rem;
          if ((new_rem == 32'sd0) && (live_q != '0)) live_d = live_q - LCNT'(1);
          l_we     = 1'b1;
          l_wused  = cnt_after != '0;
          l_wtotal = l_total_q - {{(LTW-32){delta_q[31]}}, delta_q};
          l_wcnt   = cnt_after;
        end
      end
      ST_ADD_PREP: begin
        lc_d = '0;  lfound_d = 1'b0;  lfree_v_d = 1'b0;
        tgt_bid_d = side_q == SIDE_BID;  tgt_price_d = price_q;  ctx_d = CTX_ADD;
        if (!slot_v) status_d = STS_ORD_FULL;
      end
      ST_BEST_CHK: begin
        if (lr_used_q) begin
          if (bc_q < LAW'(LEVELS_PER_SIDE)) begin
            if (!bbv_q || (lr_price_q > bb_q)) begin
              bb_d = lr_price_q;  bbv_d = 1'b1;
            end
          end else if (!bav_q || (lr_price_q < ba_q)) begin
            ba_d = lr_price_q;  bav_d = 1'b1;
          end
        end
        bc_d = bc_q + LAW'(1);
      end
      ST_EMIT: begin
        if (emit_go) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_data_d[3:0]                  = status_q;
          m_data_d[OFS_BB +: 32]         = bb_q;
          m_data_d[OFS_BBV]              = bbv_q;
          m_data_d[OFS_BA +: 32]         = ba_q;
          m_data_d[OFS_BAV]              = bav_q;
          m_data_d[OFS_HALT]             = halt_q;
          m_data_d[OFS_LIVE +: 11]       = live_q[10:0];
          m_data_d[OFS_HIDDEN +: 32]     = hid_q;
          m_data_d[OFS_CROSS +: 32]      = crs_q;
          m_data_d[OFS_UNKNOWN +: 32]    = unk_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // order memory
  always_ff @(posedge clk_i) begin
    if (o_we) begin
      ord_used_m[o_waddr]  <= o_wused;
      ord_key_m[o_waddr]   <= o_wkey;
      ord_price_m[o_waddr] <= o_wprice;
      ord_rem_m[o_waddr]   <= o_wrem;
      ord_bid_m[o_waddr]   <= o_wbid;
    end
    or_used_q  <= ord_used_m[oc_q];
    or_key_q   <= ord_key_m[oc_q];
    or_price_q <= ord_price_m[oc_q];
    or_rem_q   <= ord_rem_m[oc_q];
    or_bid_q   <= ord_bid_m[oc_q];
  end

  // level memory
  always_ff @(posedge clk_i) begin
    if (l_we) begin
      lvl_used_m[l_waddr]  <= l_wused;
      lvl_price_m[l_waddr] <= l_wprice;
      lvl_total_m[l_waddr] <= l_wtotal;
      lvl_cnt_m[l_waddr]   <= l_wcnt;
    end
    lr_used_q  <= lvl_used_m[lvl_raddr];
    lr_price_q <= lvl_price_m[lvl_raddr];
    lr_total_q <= lvl_total_m[lvl_raddr];
    lr_cnt_q   <= lvl_cnt_m[lvl_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cc_q      <= '0;
      halt_q    <= 1'b0;
      hid_q     <= '0;
      crs_q     <= '0;
      unk_q     <= '0;
      live_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cc_q      <= cc_d;
      halt_q    <= halt_d;
      hid_q     <= hid_d;
      crs_q     <= crs_d;
      unk_q     <= unk_d;
      live_q    <= live_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
    cmd_q <= cmd_d;  id_q <= id_d;  side_q <= side_d;  price_q <= price_d;  size_q <= size_d;
    status_q <= status_d;  replaced_q <= replaced_d;
    oc_q <= oc_d;  fidx_q <= fidx_d;  ofree_q <= ofree_d;  ofound_q <= ofound_d;
    ofree_v_q <= ofree_v_d;  o_price_q <= o_price_d;  o_rem_q <= o_rem_d;  o_bid_q <= o_bid_d;
    delta_q <= delta_d;
    lc_q <= lc_d;  lidx_q <= lidx_d;  lfree_q <= lfree_d;  lfound_q <= lfound_d;
    lfree_v_q <= lfree_v_d;  l_total_q <= l_total_d;  l_cnt_q <= l_cnt_d;
    tgt_bid_q <= tgt_bid_d;  tgt_price_q <= tgt_price_d;
    bc_q <= bc_d;  bb_q <= bb_d;  ba_q <= ba_d;  bbv_q <= bbv_d;  bav_q <= bav_d;
    m_data_q <= m_data_d;
  end

endmodule

// ----- sv/lobu_checker.sv -----
`timescale 1ns / 1ps
module lobu_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [lobu_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import lobu_pkg::*;

  // a pending result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("pending result changed");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready after request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[3:0] <= STS_LVL_FULL)
    else $error("status out of range");

  // an empty side reports a zero price
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[OFS_BBV] || (m_axis_tdata_o[OFS_BB +: 32] == 32'd0)) &&
      (m_axis_tdata_o[OFS_BAV] || (m_axis_tdata_o[OFS_BA +: 32] == 32'd0)))
    else $error("empty side with nonzero price");

endmodule

bind limit_order_book_update_core lobu_checker u_lobu_checker (.*);
